>>> sv/l2p_pkg.sv
`timescale 1ns / 1ps
// l2p_pkg: item types, letter codes and phoneme codes for letter_to_phoneme_rules
// no dependencies

package l2p_pkg;

	typedef logic [4:0] letter_t;
	typedef logic [5:0] phon_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		phon_t phoneme;
		logic  last;
		logic  no_phoneme;
	} out_item_t;

	localparam int unsigned WIN_LEN = 6;

	// window fill level at which the next letter makes a rule fire
	localparam logic [2:0] FILL_FULL = 3'd6;

	// result count past which an end-of-text flush stops firing
	localparam logic [3:0] FLUSH_LIMIT = 4'd12;

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
	localparam logic [7:0] ASCII_CASE_GAP = 8'h20;

	localparam letter_t LTR_A = 5'd0;
	localparam letter_t LTR_B = 5'd1;
	localparam letter_t LTR_C = 5'd2;
	localparam letter_t LTR_D = 5'd3;
	localparam letter_t LTR_E = 5'd4;
	localparam letter_t LTR_F = 5'd5;
	localparam letter_t LTR_G = 5'd6;
	localparam letter_t LTR_H = 5'd7;
	localparam letter_t LTR_I = 5'd8;
	localparam letter_t LTR_J = 5'd9;
	localparam letter_t LTR_K = 5'd10;
	localparam letter_t LTR_L = 5'd11;
	localparam letter_t LTR_M = 5'd12;
	localparam letter_t LTR_N = 5'd13;
	localparam letter_t LTR_O = 5'd14;
	localparam letter_t LTR_P = 5'd15;
	localparam letter_t LTR_R = 5'd17;
	localparam letter_t LTR_S = 5'd18;
	localparam letter_t LTR_T = 5'd19;
	localparam letter_t LTR_U = 5'd20;
	localparam letter_t LTR_V = 5'd21;
	localparam letter_t LTR_W = 5'd22;
	localparam letter_t LTR_X = 5'd23;
	localparam letter_t LTR_Y = 5'd24;
	localparam letter_t LTR_Z = 5'd25;
	localparam letter_t LTR_LAST = 5'd25;

	localparam phon_t PH_EH = 6'd0;
	localparam phon_t PH_R  = 6'd1;
	localparam phon_t PH_AA = 6'd2;
	localparam phon_t PH_EY = 6'd3;
	localparam phon_t PH_S  = 6'd4;
	localparam phon_t PH_AX = 6'd5;
	localparam phon_t PH_W  = 6'd6;
	localparam phon_t PH_AO = 6'd7;
	localparam phon_t PH_L  = 6'd8;
	localparam phon_t PH_AE = 6'd9;
	localparam phon_t PH_CH = 6'd10;
	localparam phon_t PH_K  = 6'd11;
	localparam phon_t PH_IY = 6'd12;
	localparam phon_t PH_ER = 6'd13;
	localparam phon_t PH_J  = 6'd14;
	localparam phon_t PH_G  = 6'd15;
	localparam phon_t PH_AY = 6'd16;
	localparam phon_t PH_IH = 6'd17;
	localparam phon_t PH_UW = 6'd18;
	localparam phon_t PH_AW = 6'd19;
	localparam phon_t PH_F  = 6'd20;
	localparam phon_t PH_P  = 6'd21;
	localparam phon_t PH_SH = 6'd22;
	localparam phon_t PH_ZH = 6'd23;
	localparam phon_t PH_TH = 6'd24;
	localparam phon_t PH_T  = 6'd25;
	localparam phon_t PH_AH = 6'd26;
	localparam phon_t PH_WS = 6'd27;
	localparam phon_t PH_B  = 6'd28;
	localparam phon_t PH_D  = 6'd29;
	localparam phon_t PH_H  = 6'd30;
	localparam phon_t PH_M  = 6'd31;
	localparam phon_t PH_N  = 6'd32;
	localparam phon_t PH_V  = 6'd33;
	localparam phon_t PH_Y  = 6'd34;
	localparam phon_t PH_Z  = 6'd35;
	localparam phon_t PH_Q  = 6'd36;

endpackage

>>> sv/letter_to_phoneme_rules.sv
`timescale 1ns / 1ps
// letter_to_phoneme_rules: text bytes in, phoneme codes out, ordered rule table
// depends on l2p_pkg (item types, letter and phoneme codes)

// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data  (l2p_pkg::in_item_t)
// out     | output    | out_valid / out_ready | out_data (l2p_pkg::out_item_t)
//
// pacing: one rule-table pass per cycle between the input register and the output
//   register unless out_ready stalls it; a byte that fires no rule gives no result,
//   a letter that fires a rule gives 1 to 3 phonemes, end of text 1 to 15 results
// reset: arst_n clears the window, fill level, phoneme index, flush count and valid flags
// stalls: out_ready low holds the result and an item in work that fires a rule; in_ready
//   follows the item in work, so a new item enters in the cycle its predecessor finishes

module letter_to_phoneme_rules (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  l2p_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output l2p_pkg::out_item_t  out_data
);

	// input stage
	logic               v_s1;
	l2p_pkg::in_item_t  item_s1;

	// lookahead window, oldest letter at index 0
	l2p_pkg::letter_t   win_q [l2p_pkg::WIN_LEN];
	logic [2:0]         fill_q;
	logic [1:0]         idx_q;     // which phoneme of the firing rule goes next
	logic [3:0]         cnt_q;     // results given so far in this flush

	// output register
	logic               out_valid_q;
	l2p_pkg::out_item_t out_data_q;

	// letter decode
	logic [7:0]         up_code;
	logic               is_letter;
	l2p_pkg::letter_t   in_letter;

	// per-position presence and class
	logic [l2p_pkg::WIN_LEN-1:0] pres;
	logic [l2p_pkg::WIN_LEN-1:0] vow;
	logic [l2p_pkg::WIN_LEN-1:0] cons;

	// firing rule result
	l2p_pkg::phon_t     ph0, ph1, ph2, ph_sel;
	logic [1:0]         np;
	logic               used2;

	// control
	logic               is_eot, need_fire, marker, slot_free;
	logic               done, emit, fire_end, flush_more, emit_last;
	logic [2:0]         fill_sh;
	logic [3:0]         cnt_next;
	l2p_pkg::letter_t   win_sh [l2p_pkg::WIN_LEN];

	function automatic logic is_l(input logic p, input l2p_pkg::letter_t v,
		input l2p_pkg::letter_t l);
		return p && (v == l);
	endfunction

	// fold case and spot letters
	always_comb begin
		up_code = item_s1.char_code;
		if (item_s1.char_code >= l2p_pkg::ASCII_LOWER_A &&
			item_s1.char_code <= l2p_pkg::ASCII_LOWER_Z) begin
			up_code = item_s1.char_code - l2p_pkg::ASCII_CASE_GAP;
		end
		is_letter = (up_code >= l2p_pkg::ASCII_UPPER_A) && (up_code <= l2p_pkg::ASCII_UPPER_Z);
		in_letter = 5'(up_code - l2p_pkg::ASCII_UPPER_A);
	end

	// letters past the fill level count as absent
	always_comb begin
		for (int i = 0; i < l2p_pkg::WIN_LEN; i++) begin
			pres[i] = (3'(i) < fill_q);
			vow[i]  = pres[i] && (win_q[i] == l2p_pkg::LTR_A || win_q[i] == l2p_pkg::LTR_E ||
				win_q[i] == l2p_pkg::LTR_I || win_q[i] == l2p_pkg::LTR_O ||
				win_q[i] == l2p_pkg::LTR_U || win_q[i] == l2p_pkg::LTR_Y);
			cons[i] = pres[i] && (win_q[i] <= l2p_pkg::LTR_LAST) &&
				win_q[i] != l2p_pkg::LTR_A && win_q[i] != l2p_pkg::LTR_E &&
				win_q[i] != l2p_pkg::LTR_I && win_q[i] != l2p_pkg::LTR_O &&
				win_q[i] != l2p_pkg::LTR_U;
		end
	end

	// rule table: first matching rule at the oldest letter wins
	always_comb begin
		ph0   = l2p_pkg::PH_EH;
		ph1   = l2p_pkg::PH_EH;
		ph2   = l2p_pkg::PH_EH;
		np    = 2'd1;
		used2 = 1'b0;
		case (win_q[0])
			l2p_pkg::LTR_A: begin
				if (is_l(pres[1], win_q[1], l2p_pkg::LTR_R) &&
					(is_l(pres[2], win_q[2], l2p_pkg::LTR_E) || vow[2])) begin
					ph0 = l2p_pkg::PH_EH; ph1 = l2p_pkg::PH_R; np = 2'd2;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_R)) begin
					ph0 = l2p_pkg::PH_AA; ph1 = l2p_pkg::PH_R; np = 2'd2;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_S) && vow[2]) begin
					ph0 = l2p_pkg::PH_EY; ph1 = l2p_pkg::PH_S; np = 2'd2;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_W) &&
					is_l(pres[2], win_q[2], l2p_pkg::LTR_A)) begin
					ph0 = l2p_pkg::PH_AX; ph1 = l2p_pkg::PH_W; ph2 = l2p_pkg::PH_AX;
					np = 2'd3;
				end else if (cons[1] && is_l(pres[2], win_q[2], l2p_pkg::LTR_I) && vow[3]) begin
					ph0 = l2p_pkg::PH_EY;
				end else if (cons[1] && is_l(pres[2], win_q[2], l2p_pkg::LTR_E) &&
					(is_l(pres[3], win_q[3], l2p_pkg::LTR_E) ||
					(is_l(pres[3], win_q[3], l2p_pkg::LTR_I) &&
					is_l(pres[4], win_q[4], l2p_pkg::LTR_N) &&
					is_l(pres[5], win_q[5], l2p_pkg::LTR_G)))) begin
					ph0 = l2p_pkg::PH_EY;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_Y)) begin
					ph0 = l2p_pkg::PH_EY;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_L)) begin
					ph0 = l2p_pkg::PH_AO; ph1 = l2p_pkg::PH_L; np = 2'd2;
				end else begin
					ph0 = l2p_pkg::PH_AE;
				end
			end
			l2p_pkg::LTR_C: begin
				if (is_l(pres[1], win_q[1], l2p_pkg::LTR_H)) begin
					ph0 = l2p_pkg::PH_CH; used2 = 1'b1;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_E) ||
					is_l(pres[1], win_q[1], l2p_pkg::LTR_I) ||
					is_l(pres[1], win_q[1], l2p_pkg::LTR_Y)) begin
					ph0 = l2p_pkg::PH_S;
				end else begin
					ph0 = l2p_pkg::PH_K;
				end
			end
			l2p_pkg::LTR_E: begin
				if (is_l(pres[1], win_q[1], l2p_pkg::LTR_E) ||
					is_l(pres[1], win_q[1], l2p_pkg::LTR_A)) begin
					ph0 = l2p_pkg::PH_IY; used2 = 1'b1;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_R)) begin
					ph0 = l2p_pkg::PH_ER; used2 = 1'b1;
				end else begin
					ph0 = l2p_pkg::PH_EH;
				end
			end
			l2p_pkg::LTR_G: begin
				if (is_l(pres[1], win_q[1], l2p_pkg::LTR_E) ||
					is_l(pres[1], win_q[1], l2p_pkg::LTR_I)) begin
					ph0 = l2p_pkg::PH_J;
				end else begin
					ph0 = l2p_pkg::PH_G;
				end
			end
			l2p_pkg::LTR_I: begin
				if (is_l(pres[1], win_q[1], l2p_pkg::LTR_R)) begin
					ph0 = l2p_pkg::PH_ER;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_G) &&
					is_l(pres[2], win_q[2], l2p_pkg::LTR_H)) begin
					ph0 = l2p_pkg::PH_AY;
				end else begin
					ph0 = l2p_pkg::PH_IH;
				end
			end
			l2p_pkg::LTR_O: begin
				if (is_l(pres[1], win_q[1], l2p_pkg::LTR_O)) begin
					ph0 = l2p_pkg::PH_UW; used2 = 1'b1;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_R)) begin
					ph0 = l2p_pkg::PH_AO; ph1 = l2p_pkg::PH_R; np = 2'd2; used2 = 1'b1;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_U)) begin
					ph0 = l2p_pkg::PH_AW; used2 = 1'b1;
				end else begin
					ph0 = l2p_pkg::PH_AA;
				end
			end
			l2p_pkg::LTR_P: begin
				if (is_l(pres[1], win_q[1], l2p_pkg::LTR_H)) begin
					ph0 = l2p_pkg::PH_F; used2 = 1'b1;
				end else begin
					ph0 = l2p_pkg::PH_P;
				end
			end
			l2p_pkg::LTR_S: begin
				if (is_l(pres[1], win_q[1], l2p_pkg::LTR_H)) begin
					ph0 = l2p_pkg::PH_SH; used2 = 1'b1;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_I) &&
					is_l(pres[2], win_q[2], l2p_pkg::LTR_O) &&
					is_l(pres[3], win_q[3], l2p_pkg::LTR_N)) begin
					ph0 = l2p_pkg::PH_ZH;
				end else begin
					ph0 = l2p_pkg::PH_S;
				end
			end
			l2p_pkg::LTR_T: begin
				if (is_l(pres[1], win_q[1], l2p_pkg::LTR_H)) begin
					ph0 = l2p_pkg::PH_TH; used2 = 1'b1;
				end else if (is_l(pres[1], win_q[1], l2p_pkg::LTR_I) &&
					is_l(pres[2], win_q[2], l2p_pkg::LTR_O) &&
					is_l(pres[3], win_q[3], l2p_pkg::LTR_N)) begin
					ph0 = l2p_pkg::PH_SH;
				end else begin
					ph0 = l2p_pkg::PH_T;
				end
			end
			l2p_pkg::LTR_U: begin
				if (is_l(pres[1], win_q[1], l2p_pkg::LTR_R)) begin
					ph0 = l2p_pkg::PH_ER; used2 = 1'b1;
				end else begin
					ph0 = l2p_pkg::PH_AH;
				end
			end
			l2p_pkg::LTR_W: begin
				used2 = is_l(pres[1], win_q[1], l2p_pkg::LTR_H);
				ph0   = l2p_pkg::PH_WS;
			end
			l2p_pkg::LTR_B: ph0 = l2p_pkg::PH_B;
			l2p_pkg::LTR_D: ph0 = l2p_pkg::PH_D;
			l2p_pkg::LTR_F: ph0 = l2p_pkg::PH_F;
			l2p_pkg::LTR_H: ph0 = l2p_pkg::PH_H;
			l2p_pkg::LTR_J: ph0 = l2p_pkg::PH_J;
			l2p_pkg::LTR_K: ph0 = l2p_pkg::PH_K;
			l2p_pkg::LTR_L: ph0 = l2p_pkg::PH_L;
			l2p_pkg::LTR_M: ph0 = l2p_pkg::PH_M;
			l2p_pkg::LTR_N: ph0 = l2p_pkg::PH_N;
			l2p_pkg::LTR_R: ph0 = l2p_pkg::PH_R;
			l2p_pkg::LTR_V: ph0 = l2p_pkg::PH_V;
			l2p_pkg::LTR_X: begin
				ph0 = l2p_pkg::PH_K; ph1 = l2p_pkg::PH_S; np = 2'd2;
			end
			l2p_pkg::LTR_Y: ph0 = l2p_pkg::PH_Y;
			l2p_pkg::LTR_Z: ph0 = l2p_pkg::PH_Z;
			default: ph0 = l2p_pkg::PH_Q; // letter Q has no rule
		endcase
	end

	// pick the phoneme for this cycle
	always_comb begin
		case (idx_q)
			2'd0:    ph_sel = ph0;
			2'd1:    ph_sel = ph1;
			default: ph_sel = ph2;
		endcase
	end

	// window after the firing rule consumes one or two letters
	always_comb begin
		fill_sh = used2 ? (fill_q - 3'd2) : (fill_q - 3'd1);
		for (int i = 0; i < l2p_pkg::WIN_LEN; i++) win_sh[i] = '0;
		if (used2) begin
			for (int i = 0; i < l2p_pkg::WIN_LEN - 2; i++) win_sh[i] = win_q[i + 2];
		end else begin
			for (int i = 0; i < l2p_pkg::WIN_LEN - 1; i++) win_sh[i] = win_q[i + 1];
		end
	end

	// sequencing of the item in work
	always_comb begin
		is_eot     = item_s1.end_of_text;
		need_fire  = is_eot ? (fill_q != 3'd0) : (is_letter && fill_q == l2p_pkg::FILL_FULL);
		marker     = is_eot && (fill_q == 3'd0);
		slot_free  = !out_valid_q || out_ready;
		fire_end   = 1'b0;
		done       = 1'b0;
		emit       = 1'b0;
		emit_last  = 1'b0;
		cnt_next   = cnt_q + {2'b00, np};
		flush_more = (fill_sh != 3'd0) && (cnt_next <= l2p_pkg::FLUSH_LIMIT);
		if (v_s1) begin
			if (marker) begin
				// empty text: one marker item
				emit      = slot_free;
				emit_last = 1'b1;
				done      = slot_free;
			end else if (need_fire) begin
				emit = slot_free;
				if (slot_free && idx_q == np - 2'd1) begin
					fire_end  = 1'b1;
					emit_last = is_eot && !flush_more;
					done      = !is_eot || !flush_more;
				end
			end else begin
				// letter appended, or non-letter dropped
				done = 1'b1;
			end
		end
	end

	assign in_ready  = !v_s1 || done;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// window, fill and flush count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < l2p_pkg::WIN_LEN; i++) win_q[i] <= '0;
			fill_q <= '0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (v_s1) begin
			if (is_eot) begin
				if (done) begin
					// end of text returns the window to empty
					for (int i = 0; i < l2p_pkg::WIN_LEN; i++) win_q[i] <= '0;
					fill_q <= '0;
					idx_q  <= '0;
					cnt_q  <= '0;
				end else if (fire_end) begin
					win_q  <= win_sh;
					fill_q <= fill_sh;
					idx_q  <= '0;
					cnt_q  <= cnt_next;
				end else if (emit) begin
					idx_q <= idx_q + 2'd1;
				end
			end else if (need_fire) begin
				if (fire_end) begin
					// consume, then append the new letter behind what is left
					for (int i = 0; i < l2p_pkg::WIN_LEN; i++) begin
						win_q[i] <= (3'(i) == fill_sh) ? in_letter : win_sh[i];
					end
					fill_q <= fill_sh + 3'd1;
					idx_q  <= '0;
				end else if (emit) begin
					idx_q <= idx_q + 2'd1;
				end
			end else if (is_letter) begin
				for (int i = 0; i < l2p_pkg::WIN_LEN; i++) begin
					if (3'(i) == fill_q) win_q[i] <= in_letter;
				end
				fill_q <= fill_q + 3'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.phoneme    <= marker ? l2p_pkg::PH_EH : ph_sel;
			out_data_q.last       <= emit_last;
			out_data_q.no_phoneme <= marker;
		end
	end

endmodule

>>> sim/tb_letter_to_phoneme_rules.sv
`timescale 1ns / 1ps
// tb_letter_to_phoneme_rules: self-checking testbench for letter_to_phoneme_rules
// feeds text bytes and end-of-text marks, predicts the phoneme stream and checks it
// depends on l2p_pkg and letter_to_phoneme_rules

module tb_letter_to_phoneme_rules;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 6;
	localparam int TEXT_ITEMS   = 230;
	localparam int MAX_GAP      = 13;
	// worst honest silence is one sender gap plus one receiver stall, far below this
	localparam int IDLE_LIMIT   = 4000;
	// flush can give up to 15 results at one per cycle when not stalled, plus margin
	localparam int TAIL_CYCLES  = 40;
	localparam int REPORT_MAX   = 10;
	localparam int HOLD_EVERY   = 90;
	localparam int N_FRAGS      = 36;

	// one queued byte; hold makes the driver wait for every due phoneme first
	typedef struct packed {
		logic              hold;
		l2p_pkg::in_item_t item;
	} text_byte_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	l2p_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	l2p_pkg::out_item_t out_data;

	letter_to_phoneme_rules dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// text still to be sent and phonemes still to arrive
	text_byte_t         text_q[$];
	l2p_pkg::out_item_t phonemes_due[$];

	// predictor state: lookahead window of letters and its fill level
	l2p_pkg::letter_t   win [0:l2p_pkg::WIN_LEN-1];
	int                 fill;
	// phonemes produced by one input item, before they go to the due queue
	l2p_pkg::out_item_t rule_out [0:15];
	int                 n_rule_out;

	int n_launched;
	int n_accepted;
	int n_results;
	int rx_seen;
	int mismatches;
	int idle_cycles;
	int tx_gap;
	int rx_stall;
	bit tx_burst;
	bit rx_burst;
	text_byte_t         nxt;
	l2p_pkg::out_item_t want;

	// letter syllables that reach the context rules with random case on top
	string frags [0:N_FRAGS-1] = '{
		"ARE", "ARI", "ARK", "ASA", "AWA", "AMIA", "ATEE", "ABEING", "AY", "AL",
		"CH", "CE", "CI", "CY", "EE", "EA", "ER", "GE", "GI", "IR",
		"IGH", "OO", "OR", "OU", "PH", "SH", "SION", "TH", "TION", "UR",
		"WH", "Q", "X", "Y", "Z", "J"
	};

	// ---------------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------------

	// letter at window slot i, or -1 where the slot is past the held letters
	function automatic int ltr_at(int i);
		return (i < fill) ? int'(win[i]) : -1;
	endfunction

	function automatic bit has(int i, l2p_pkg::letter_t l);
		return ltr_at(i) == int'(l);
	endfunction

	// Y counts as a vowel for right contexts but also as a consonant
	function automatic bit vowel_at(int i);
		int c;
		c = ltr_at(i);
		return c == l2p_pkg::LTR_A || c == l2p_pkg::LTR_E || c == l2p_pkg::LTR_I ||
			c == l2p_pkg::LTR_O || c == l2p_pkg::LTR_U || c == l2p_pkg::LTR_Y;
	endfunction

	function automatic bit cons_at(int i);
		int c;
		c = ltr_at(i);
		return c >= 0 && c != l2p_pkg::LTR_A && c != l2p_pkg::LTR_E &&
			c != l2p_pkg::LTR_I && c != l2p_pkg::LTR_O && c != l2p_pkg::LTR_U;
	endfunction

	// first matching rule at the oldest letter: emit its phonemes, drop its letters
	task automatic fire_rule();
		l2p_pkg::phon_t ph [0:2];
		int             np;
		int             used;
		int             i;
		ph[0] = l2p_pkg::PH_EH;
		ph[1] = l2p_pkg::PH_EH;
		ph[2] = l2p_pkg::PH_EH;
		np = 1;
		used = 1;
		case (win[0])
			l2p_pkg::LTR_A: begin
				if (has(1, l2p_pkg::LTR_R) && (has(2, l2p_pkg::LTR_E) || vowel_at(2))) begin
					ph[0] = l2p_pkg::PH_EH; ph[1] = l2p_pkg::PH_R; np = 2;
				end else if (has(1, l2p_pkg::LTR_R)) begin
					ph[0] = l2p_pkg::PH_AA; ph[1] = l2p_pkg::PH_R; np = 2;
				end else if (has(1, l2p_pkg::LTR_S) && vowel_at(2)) begin
					ph[0] = l2p_pkg::PH_EY; ph[1] = l2p_pkg::PH_S; np = 2;
				end else if (has(1, l2p_pkg::LTR_W) && has(2, l2p_pkg::LTR_A)) begin
					ph[0] = l2p_pkg::PH_AX; ph[1] = l2p_pkg::PH_W; ph[2] = l2p_pkg::PH_AX;
					np = 3;
				end else if (cons_at(1) && has(2, l2p_pkg::LTR_I) && vowel_at(3)) begin
					ph[0] = l2p_pkg::PH_EY;
				end else if (cons_at(1) && has(2, l2p_pkg::LTR_E) &&
						(has(3, l2p_pkg::LTR_E) || (has(3, l2p_pkg::LTR_I) &&
						has(4, l2p_pkg::LTR_N) && has(5, l2p_pkg::LTR_G)))) begin
					ph[0] = l2p_pkg::PH_EY;
				end else if (has(1, l2p_pkg::LTR_Y)) begin
					ph[0] = l2p_pkg::PH_EY;
				end else if (has(1, l2p_pkg::LTR_L)) begin
					ph[0] = l2p_pkg::PH_AO; ph[1] = l2p_pkg::PH_L; np = 2;
				end else begin
					ph[0] = l2p_pkg::PH_AE;
				end
			end
			l2p_pkg::LTR_C: begin
				if (has(1, l2p_pkg::LTR_H)) begin
					ph[0] = l2p_pkg::PH_CH; used = 2;
				end else if (has(1, l2p_pkg::LTR_E) || has(1, l2p_pkg::LTR_I) ||
						has(1, l2p_pkg::LTR_Y)) begin
					ph[0] = l2p_pkg::PH_S;
				end else begin
					ph[0] = l2p_pkg::PH_K;
				end
			end
			l2p_pkg::LTR_E: begin
				if (has(1, l2p_pkg::LTR_E) || has(1, l2p_pkg::LTR_A)) begin
					ph[0] = l2p_pkg::PH_IY; used = 2;
				end else if (has(1, l2p_pkg::LTR_R)) begin
					ph[0] = l2p_pkg::PH_ER; used = 2;
				end else begin
					ph[0] = l2p_pkg::PH_EH;
				end
			end
			l2p_pkg::LTR_G: begin
				ph[0] = (has(1, l2p_pkg::LTR_E) || has(1, l2p_pkg::LTR_I)) ?
					l2p_pkg::PH_J : l2p_pkg::PH_G;
			end
			l2p_pkg::LTR_I: begin
				if (has(1, l2p_pkg::LTR_R))
					ph[0] = l2p_pkg::PH_ER;
				else if (has(1, l2p_pkg::LTR_G) && has(2, l2p_pkg::LTR_H))
					ph[0] = l2p_pkg::PH_AY;
				else
					ph[0] = l2p_pkg::PH_IH;
			end
			l2p_pkg::LTR_O: begin
				if (has(1, l2p_pkg::LTR_O)) begin
					ph[0] = l2p_pkg::PH_UW; used = 2;
				end else if (has(1, l2p_pkg::LTR_R)) begin
					ph[0] = l2p_pkg::PH_AO; ph[1] = l2p_pkg::PH_R; np = 2; used = 2;
				end else if (has(1, l2p_pkg::LTR_U)) begin
					ph[0] = l2p_pkg::PH_AW; used = 2;
				end else begin
					ph[0] = l2p_pkg::PH_AA;
				end
			end
			l2p_pkg::LTR_P: begin
				if (has(1, l2p_pkg::LTR_H)) begin
					ph[0] = l2p_pkg::PH_F; used = 2;
				end else begin
					ph[0] = l2p_pkg::PH_P;
				end
			end
			l2p_pkg::LTR_S: begin
				if (has(1, l2p_pkg::LTR_H)) begin
					ph[0] = l2p_pkg::PH_SH; used = 2;
				end else if (has(1, l2p_pkg::LTR_I) && has(2, l2p_pkg::LTR_O) &&
						has(3, l2p_pkg::LTR_N)) begin
					ph[0] = l2p_pkg::PH_ZH;
				end else begin
					ph[0] = l2p_pkg::PH_S;
				end
			end
			l2p_pkg::LTR_T: begin
				if (has(1, l2p_pkg::LTR_H)) begin
					ph[0] = l2p_pkg::PH_TH; used = 2;
				end else if (has(1, l2p_pkg::LTR_I) && has(2, l2p_pkg::LTR_O) &&
						has(3, l2p_pkg::LTR_N)) begin
					ph[0] = l2p_pkg::PH_SH;
				end else begin
					ph[0] = l2p_pkg::PH_T;
				end
			end
			l2p_pkg::LTR_U: begin
				if (has(1, l2p_pkg::LTR_R)) begin
					ph[0] = l2p_pkg::PH_ER; used = 2;
				end else begin
					ph[0] = l2p_pkg::PH_AH;
				end
			end
			l2p_pkg::LTR_W: begin
				if (has(1, l2p_pkg::LTR_H))
					used = 2;
				ph[0] = l2p_pkg::PH_WS;
			end
			l2p_pkg::LTR_B: ph[0] = l2p_pkg::PH_B;
			l2p_pkg::LTR_D: ph[0] = l2p_pkg::PH_D;
			l2p_pkg::LTR_F: ph[0] = l2p_pkg::PH_F;
			l2p_pkg::LTR_H: ph[0] = l2p_pkg::PH_H;
			l2p_pkg::LTR_J: ph[0] = l2p_pkg::PH_J;
			l2p_pkg::LTR_K: ph[0] = l2p_pkg::PH_K;
			l2p_pkg::LTR_L: ph[0] = l2p_pkg::PH_L;
			l2p_pkg::LTR_M: ph[0] = l2p_pkg::PH_M;
			l2p_pkg::LTR_N: ph[0] = l2p_pkg::PH_N;
			l2p_pkg::LTR_R: ph[0] = l2p_pkg::PH_R;
			l2p_pkg::LTR_V: ph[0] = l2p_pkg::PH_V;
			l2p_pkg::LTR_X: begin
				ph[0] = l2p_pkg::PH_K; ph[1] = l2p_pkg::PH_S; np = 2;
			end
			l2p_pkg::LTR_Y: ph[0] = l2p_pkg::PH_Y;
			l2p_pkg::LTR_Z: ph[0] = l2p_pkg::PH_Z;
			default: ph[0] = l2p_pkg::PH_Q;  // Q has no rule of its own
		endcase
		for (i = 0; i < np; i++) begin
			rule_out[n_rule_out].phoneme    = ph[i];
			rule_out[n_rule_out].last       = 1'b0;
			rule_out[n_rule_out].no_phoneme = 1'b0;
			n_rule_out++;
		end
		// a two-letter match on the last held letter only consumes that letter
		if (used > fill)
			used = fill;
		for (i = 0; i < l2p_pkg::WIN_LEN; i++)
			win[i] = (i + used < l2p_pkg::WIN_LEN) ? win[i + used] : '0;
		fill = fill - used;
	endtask

	// work out the phonemes that one accepted item causes
	task automatic predict_phonemes(l2p_pkg::in_item_t it);
		logic [7:0] ch;
		int         i;
		n_rule_out = 0;
		if (it.end_of_text) begin
			// flush: fire until the window is empty or the result cap is passed
			while (fill > 0 && n_rule_out <= l2p_pkg::FLUSH_LIMIT)
				fire_rule();
			if (n_rule_out == 0) begin
				// empty text gives one marker result
				rule_out[0].phoneme    = l2p_pkg::PH_EH;
				rule_out[0].last       = 1'b1;
				rule_out[0].no_phoneme = 1'b1;
				n_rule_out = 1;
			end else begin
				rule_out[n_rule_out - 1].last = 1'b1;
			end
			for (i = 0; i < l2p_pkg::WIN_LEN; i++)
				win[i] = '0;
			fill = 0;
		end else begin
			ch = it.char_code;
			if (ch >= l2p_pkg::ASCII_LOWER_A && ch <= l2p_pkg::ASCII_LOWER_Z)
				ch = ch - l2p_pkg::ASCII_CASE_GAP;
			// non-letters drop out without a trace
			if (ch >= l2p_pkg::ASCII_UPPER_A && ch <= l2p_pkg::ASCII_UPPER_Z) begin
				if (fill >= l2p_pkg::WIN_LEN)
					fire_rule();
				win[fill] = l2p_pkg::letter_t'(ch - l2p_pkg::ASCII_UPPER_A);
				fill++;
			end
		end
		for (i = 0; i < n_rule_out; i++)
			phonemes_due = {phonemes_due, rule_out[i]};
	endtask

	// ---------------------------------------------------------------------------
	// text building
	// ---------------------------------------------------------------------------

	task automatic add_byte(logic [7:0] b, logic eot, logic hold);
		text_byte_t t;
		t.hold             = hold;
		t.item.char_code   = b;
		t.item.end_of_text = eot;
		text_q = {text_q, t};
	endtask

	// upper-case letter in, either case out
	function automatic logic [7:0] any_case(logic [7:0] up);
		return $urandom_range(0, 1) ? up + l2p_pkg::ASCII_CASE_GAP : up;
	endfunction

	task automatic add_word(string w, logic hold);
		int j;
		for (j = 0; j < w.len(); j++)
			add_byte(any_case(w[j]), 1'b0, hold && j == 0);
	endtask

	// ---------------------------------------------------------------------------
	// clock and reset
	// ---------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// reset once at the start, released on a falling edge
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ---------------------------------------------------------------------------
	// driver: one item from text_q at a time, random gap after each launch
	// ---------------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (n_launched != n_accepted) begin
				// item still waiting for in_ready: valid and payload stay put
			end else if (tx_gap > 0) begin
				in_valid <= 1'b0;
				tx_gap--;
			end else begin
				if (text_q.size() != 0)
					nxt = text_q[0];
				// a held item waits until every due phoneme has been seen
				if (text_q.size() == 0 || (nxt.hold && phonemes_due.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					nxt = text_q.pop_front();
					in_data  <= nxt.item;
					in_valid <= 1'b1;
					n_launched++;
					// switch now and then between gaps and back-to-back items
					if ($urandom_range(0, 15) == 0)
						tx_burst = !tx_burst;
					tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// receiver: random stall after each result, with stall-free stretches
	// ---------------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (n_results != rx_seen) begin
				rx_seen = n_results;
				if ($urandom_range(0, 15) == 0)
					rx_burst = !rx_burst;
				rx_stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (rx_stall > 0) begin
				out_ready <= 1'b0;
				rx_stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// monitor: check results, predict accepted items, watch for a hang
	// ---------------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			// results first: an item accepted at this edge cannot have caused one yet
			if (out_valid && out_ready) begin
				n_results++;
				if (phonemes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("result %0d unexpected: ph=%0d last=%0b none=%0b",
							n_results, out_data.phoneme, out_data.last,
							out_data.no_phoneme);
				end else begin
					want = phonemes_due.pop_front();
					if (out_data.phoneme !== want.phoneme || out_data.last !== want.last ||
							out_data.no_phoneme !== want.no_phoneme) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"result %0d: expected ph=%0d last=%0b none=%0b,",
								" got ph=%0d last=%0b none=%0b"},
								n_results, want.phoneme, want.last, want.no_phoneme,
								out_data.phoneme, out_data.last, out_data.no_phoneme);
					end
				end
			end
			if (in_valid && in_ready) begin
				n_accepted++;
				predict_phonemes(in_data);
			end
			if ((out_valid && out_ready) || (in_valid && in_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: %0d cycles without a handshake", idle_cycles);
				$display("tb_letter_to_phoneme_rules NOT OK");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------------------

	initial begin : stimulus
		int    n_text;
		int    pick;
		int    next_hold;
		logic  hold_now;
		string w;

		for (int i = 0; i < l2p_pkg::WIN_LEN; i++)
			win[i] = '0;
		fill = 0;

		// empty text straight after reset: marker result only
		add_byte(8'h00, 1'b1, 1'b1);
		// byte extremes and the outer neighbors of the letter ranges are all dropped
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'hff, 1'b0, 1'b0);
		add_byte("@", 1'b0, 1'b0);
		add_byte("{", 1'b0, 1'b0);
		// letter range ends in both cases, Q without a rule, flush with char_code ignored
		add_byte("A", 1'b0, 1'b0);
		add_byte("z", 1'b0, 1'b0);
		add_byte("q", 1'b0, 1'b0);
		add_byte("Z", 1'b0, 1'b0);
		add_byte("a", 1'b0, 1'b0);
		add_byte("A", 1'b1, 1'b0);
		// full window of two-phoneme letters: flush reaches the result cap exactly
		add_word("XXXXXX", 1'b0);
		add_byte(8'hff, 1'b1, 1'b0);
		// seven letters: the seventh fires a rule on a full window
		add_word("SHOWERS", 1'b0);
		add_byte(8'h20, 1'b1, 1'b0);

		// random text: mostly rule fragments and letters, some noise and text ends
		n_text = 0;
		next_hold = 0;
		while (n_text < TEXT_ITEMS) begin
			pick = $urandom_range(0, 99);
			hold_now = n_text >= next_hold;
			if (hold_now)
				next_hold += HOLD_EVERY;
			if (pick < 5) begin
				add_byte(8'($urandom_range(0, 255)), 1'b1, hold_now);
				n_text++;
			end else if (pick < 15) begin
				add_byte(8'($urandom_range(0, 255)), 1'b0, hold_now);
			end else if (pick < 55) begin
				w = frags[$urandom_range(0, N_FRAGS - 1)];
				add_word(w, hold_now);
				n_text += w.len();
			end else begin
				add_byte(any_case(l2p_pkg::ASCII_UPPER_A +
					8'($urandom_range(0, l2p_pkg::LTR_LAST))), 1'b0, hold_now);
				n_text++;
			end
		end
		add_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);

		// wait for all text to go in and all phonemes to come out
		while (text_q.size() != 0 || n_launched != n_accepted || phonemes_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (phonemes_due.size() != 0) begin
			$display("%0d expected results never arrived", phonemes_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("tb_letter_to_phoneme_rules OK");
		else
			$display("tb_letter_to_phoneme_rules NOT OK");
		$finish;
	end

endmodule
